/* src/mlkem_ciphertext_unpack_defines.svh */
// assertion macros for the ciphertext unpacker
`ifndef MLKEM_CIPHERTEXT_UNPACK_DEFINES_SVH
`define MLKEM_CIPHERTEXT_UNPACK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHK_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ciphertext unpack check failed");

// next-cycle implication, checked outside reset
`define CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ciphertext unpack check failed");

`endif

/* src/mlkcu_pkg.sv */
// types, constants and helper functions of the ciphertext unpacker
`timescale 1ns / 1ps
`default_nettype none

package mlkcu_pkg;

    localparam int COEFS_PER_POLY = 256;
    localparam logic [7:0] COEF_LAST = 8'(COEFS_PER_POLY - 1);
    localparam logic [2:0] MAX_U_POLYS = 3'd4;
    localparam logic [11:0] KYBER_Q = 12'd3329;
    localparam logic [4:0] DU = 5'd11;
    localparam logic [4:0] DV = 5'd5;
    localparam logic [4:0] FILL_LIMIT = 5'd10;

    // raw result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    // one field taken from the bit buffer, with the state after it
    typedef struct packed {
        logic        take;
        logic [10:0] x;
        logic        v;
        logic        eoc;
        logic [2:0]  poly_at;
        logic [7:0]  coef_at;
        logic [17:0] bitbuf;
        logic [4:0]  bits;
        logic [2:0]  poly;
        logic [7:0]  coef;
    } t_field;

    // queued result before decompression
    typedef struct packed {
        logic [10:0] x;
        logic [2:0]  poly;
        logic [7:0]  coef;
        logic        v;
        logic        eoc;
        logic        last;
    } t_raw;

    // clamp the programmed count into 1..MAX_U_POLYS
    function automatic logic [2:0] eff_count(input logic [2:0] cfg);
        logic [2:0] c;
        c = cfg;
        if (c == 3'd0) c = 3'd1;
        if (c > MAX_U_POLYS) c = MAX_U_POLYS;
        return c;
    endfunction

    // try to take one 11-bit or 5-bit field and advance the counters
    function automatic t_field take_field(input logic [17:0] bitbuf, input logic [4:0] bits,
                                          input logic [2:0] poly, input logic [7:0] coef,
                                          input logic [2:0] cnt);
        t_field     f;
        logic       v;
        logic [4:0] d;
        v         = (poly >= cnt);
        d         = v ? DV : DU;
        f.take    = (bits >= d);
        f.v       = v;
        f.eoc     = v && (coef == COEF_LAST);
        f.poly_at = poly;
        f.coef_at = coef;
        f.x       = v ? {6'd0, bitbuf[4:0]} : bitbuf[10:0];
        f.bitbuf  = bitbuf;
        f.bits    = bits;
        f.poly    = poly;
        f.coef    = coef;
        if (f.take) begin
            f.bitbuf = v ? (bitbuf >> DV) : (bitbuf >> DU);
            f.bits   = bits - d;
            if (coef >= COEF_LAST) begin
                f.coef = 8'd0;
                f.poly = v ? 3'd0 : poly + 3'd1;
            end else begin
                f.coef = coef + 8'd1;
            end
        end
        return f;
    endfunction

    // (x*q + half) >> d for the two field widths
    function automatic logic [11:0] decompress(input logic [10:0] x, input logic v);
        logic [22:0] p;
        p = 23'(x) * 23'(KYBER_Q) + (v ? 23'd16 : 23'd1024);
        return v ? p[16:5] : p[22:11];
    endfunction

endpackage

`default_nettype wire

/* src/mlkem_ciphertext_unpack.sv */
// ciphertext byte decode and decompress, du 11 and dv 5
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall  | i_cipher_byte, i_start_new
//  result  | out       | o_valid / i_stall  | o_coefficient, o_poly_index, o_coef_index,
//          |           |                    | o_is_v, o_end_of_ciphertext, o_last_of_item
//  config  | in        | i_cfg_we           | i_cfg_data (u polynomial count)
//
// a byte is accepted while o_stall is low and its 0..2 fields go into a 4-entry raw queue
// one result leaves per cycle through the output register while i_stall is low, so new
// bytes can be accepted while fields of earlier bytes still wait in the queue
// synchronous active-low reset empties the queue and clears buffer and counters
// o_stall rises while fewer than two queue entries are free
`timescale 1ns / 1ps
`default_nettype none
`include "mlkem_ciphertext_unpack_defines.svh"

module mlkem_ciphertext_unpack (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_cipher_byte,
    input  wire logic        i_start_new,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_coefficient,
    output logic [2:0]       o_poly_index,
    output logic [7:0]       o_coef_index,
    output logic             o_is_v,
    output logic             o_end_of_ciphertext,
    output logic             o_last_of_item
);

    logic [2:0]  r_cfg;
    logic [17:0] r_bitbuf, n_bitbuf;
    logic [4:0]  r_bits, n_bits;
    logic [2:0]  r_poly, n_poly;
    logic [7:0]  r_coef, n_coef;

    mlkcu_pkg::t_raw r_q [mlkcu_pkg::Q_DEPTH];
    logic [mlkcu_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [mlkcu_pkg::Q_CW-1:0] r_count, n_count;

    logic        r_o_valid;
    logic [11:0] r_coefficient;
    logic [2:0]  r_poly_index;
    logic [7:0]  r_coef_index;
    logic        r_is_v, r_eoc, r_last;

    logic            acc, push0, push1, pop;
    logic [17:0]     b0, b1;
    logic [4:0]      h0, h1;
    logic [2:0]      p0, cnt;
    logic [7:0]      c0;
    mlkcu_pkg::t_field f1, f2;
    mlkcu_pkg::t_raw   e0, e1, head;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_count > mlkcu_pkg::Q_CW'(mlkcu_pkg::Q_DEPTH - 2));
    assign cnt     = mlkcu_pkg::eff_count(r_cfg);

    // start flag, byte insert and up to two field extractions
    always_comb begin
        b0 = i_start_new ? 18'd0 : r_bitbuf;
        h0 = i_start_new ? 5'd0  : r_bits;
        p0 = i_start_new ? 3'd0  : r_poly;
        c0 = i_start_new ? 8'd0  : r_coef;
        if (h0 <= mlkcu_pkg::FILL_LIMIT) begin
            b1 = b0 | (18'(i_cipher_byte) << h0);
            h1 = h0 + 5'd8;
        end else begin
            b1 = b0;
            h1 = h0;
        end
        f1 = mlkcu_pkg::take_field(b1, h1, p0, c0, cnt);
        f2 = mlkcu_pkg::take_field(f1.bitbuf, f1.bits, f1.poly, f1.coef, cnt);
        push0 = acc && f1.take;
        push1 = acc && f1.take && f2.take;
        e0 = '{x: f1.x, poly: f1.poly_at, coef: f1.coef_at, v: f1.v, eoc: f1.eoc,
               last: !f2.take};
        e1 = '{x: f2.x, poly: f2.poly_at, coef: f2.coef_at, v: f2.v, eoc: f2.eoc,
               last: 1'b1};
        n_bitbuf = f2.bitbuf;
        n_bits   = f2.bits;
        n_poly   = f2.poly;
        n_coef   = f2.coef;
    end

    // queue head into the output register
    assign head    = r_q[r_rd];
    assign pop     = (r_count != '0) && (!r_o_valid || !i_stall);
    assign n_count = r_count + mlkcu_pkg::Q_CW'(push0) + mlkcu_pkg::Q_CW'(push1)
                     - mlkcu_pkg::Q_CW'(pop);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= mlkcu_pkg::MAX_U_POLYS;
            r_bitbuf  <= '0;
            r_bits    <= '0;
            r_poly    <= '0;
            r_coef    <= '0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (acc) begin
                r_bitbuf <= n_bitbuf;
                r_bits   <= n_bits;
                r_poly   <= n_poly;
                r_coef   <= n_coef;
            end
            r_wr    <= r_wr + mlkcu_pkg::Q_AW'(push0) + mlkcu_pkg::Q_AW'(push1);
            r_rd    <= r_rd + mlkcu_pkg::Q_AW'(pop);
            r_count <= n_count;
            if (pop) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // queue entries and result payload
    always_ff @(posedge i_clk) begin
        if (push0) r_q[r_wr] <= e0;
        if (push1) r_q[r_wr + mlkcu_pkg::Q_AW'(1)] <= e1;
        if (pop) begin
            r_coefficient <= mlkcu_pkg::decompress(head.x, head.v);
            r_poly_index  <= head.poly;
            r_coef_index  <= head.coef;
            r_is_v        <= head.v;
            r_eoc         <= head.eoc;
            r_last        <= head.last;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_coefficient       = r_coefficient;
    assign o_poly_index        = r_poly_index;
    assign o_coef_index        = r_coef_index;
    assign o_is_v              = r_is_v;
    assign o_end_of_ciphertext = r_eoc;
    assign o_last_of_item      = r_last;

    // checks
    `CHK_NOW(a_q_bound, 1'b1, r_count <= mlkcu_pkg::Q_CW'(mlkcu_pkg::Q_DEPTH))
    `CHK_NOW(a_coef_range, r_o_valid, r_coefficient < mlkcu_pkg::KYBER_Q)
    `CHK_NOW(a_eoc_pos, r_o_valid && r_eoc, r_is_v && (r_coef_index == mlkcu_pkg::COEF_LAST))
    `CHK_NEXT(a_drain, (r_count != '0) && !(r_o_valid && i_stall), r_o_valid)

endmodule

`default_nettype wire
